@@ src/charged_particle_force_step_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Charged particle force step unit: assertion macros
// Concurrent check helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CHARGED_PARTICLE_FORCE_STEP_UNIT_DEFINES_SVH
`define CHARGED_PARTICLE_FORCE_STEP_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CPFS_ASSERT_NOW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define CPFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPFS_ASSERT_NOW(lbl, expr, msg)
`define CPFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/cpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Charged particle force step unit: package
// Widths, codes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package cpfs_pkg;
	localparam int DW         = 32;
	localparam int FB         = 16;
	localparam int NUM_W      = 80;
	localparam int DEN_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int MW         = 33;
	localparam int PW         = 2 * MW;
	localparam int SATW       = 67;
	localparam int CW         = 49;
	localparam int SHW        = 2 * DW - FB;
	localparam int IN_DATA_W  = 7 * DW;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 6 * DW;
	localparam int CFG_ADDR_W = 3;
	localparam int IM_W       = 31;

	localparam logic [DEN_W-1:0] NEAR_SQ   = DEN_W'(4295);
	localparam logic [NUM_W-1:0] CAP_FORCE = NUM_W'(32'h7FFF_FFFF);
	localparam logic [NUM_W-1:0] CAP_UNIT  = NUM_W'(1) << FB;

	localparam logic signed [SATW-1:0] SAT_HI = SATW'(64'sh7FFF_FFFF);
	localparam logic signed [SATW-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [1:0] {
		OP_PARTICLE,
		OP_WIRE,
		OP_TICK,
		OP_RESTART
	} opcode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_COULOMB_GAIN,
		REG_MAGNETIC_GAIN,
		REG_OWN_CHARGE,
		REG_INVERSE_MASS,
		REG_START_X,
		REG_START_Y,
		REG_START_Z
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIFF, ST_SQ_MUL, ST_SQ_ACC,
		ST_C_CHK, ST_C_P, ST_C_G1, ST_C_G2, ST_C_G3, ST_C_DIVM, ST_C_WAITM,
		ST_C_UDIV, ST_C_UWAIT, ST_C_UF,
		ST_L_CHK, ST_L_X1, ST_L_X2, ST_L_X3, ST_L_G1, ST_L_G2, ST_L_G3,
		ST_L_DIV, ST_L_DWAIT, ST_L_V1, ST_L_V2, ST_L_V3, ST_L_V4, ST_L_V5,
		ST_T_MUL, ST_T_UPD, ST_T_OUT
	} state_t;

	function automatic logic signed [DW-1:0] sat32(input logic signed [SATW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > SAT_HI)
			r = DW'(SAT_HI);
		else if (v < SAT_LO)
			r = DW'(SAT_LO);
		else
			r = $signed(v[DW-1:0]);
		return r;
	endfunction
endpackage

@@ src/charged_particle_force_step_unit.sv @@
// ----------------------------------------------------------------------------
// Charged particle force step unit
// Coulomb and Lorentz force accumulation and Euler stepping in Q16.16.
// ----------------------------------------------------------------------------
// Particle item: up to four divisions, root alongside. Wire item: up to three
// divisions. Tick: one result; restart: no result. One item at a time, ready
// only when idle. Reset clears state, loads registers.
// ----------------------------------------------------------------------------
module charged_particle_force_step_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [cpfs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [cpfs_pkg::DW-1:0]          cfg_wr_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z, other_charge
	input  logic [cpfs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// opcode
	input  logic [cpfs_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y, vel_out_z
	output logic [cpfs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import cpfs_pkg::*;
	`include "charged_particle_force_step_unit_defines.svh"

	state_t state_q, state_d;
	logic [1:0] idx_q, idx_nxt, idx_j, idx_k;
	opcode_t op_q;

	logic signed [DW-1:0] pos_q [3];
	logic signed [DW-1:0] vel_q [3];
	logic signed [DW-1:0] frc_q [3];
	logic signed [DW-1:0] a_q [3];
	logic signed [DW-1:0] b_q [3];
	logic signed [DW-1:0] d_q [3];
	logic signed [DW-1:0] w_q [3];
	logic signed [DW-1:0] q2_q;
	logic signed [CW-1:0] c_q [3];
	logic signed [DW-1:0] bf_q [3];
	logic signed [DW-1:0] x_q;

	logic [DW-1:0]        cg_q, mg_q;
	logic signed [DW-1:0] oc_q;
	logic [IM_W-1:0]      im_q;
	logic signed [DW-1:0] st_q [3];

	logic [DEN_W-1:0]       s_q;
	logic signed [DEN_W-1:0] p_q;
	logic [DEN_W-1:0]       e_q;
	logic [DW-1:0]          m_q;
	logic signed [SHW-1:0]  tmp_q;
	logic [OUT_DATA_W-1:0]  out_q;
	logic                   out_valid_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;
	logic signed [SHW-1:0] prod_sh;

	logic             div_start, sqrt_start, out_load;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] div_den;
	logic [ROOT_W-1:0] root;
	unit_stat_t       div_stat, sqrt_stat;

	logic [DEN_W-1:0]     pmag;
	logic [DW-1:0]        dmag;
	logic [CW-2:0]        cmag;
	logic [DW-1:0]        q_force;
	logic [FB:0]          q_unit;
	logic signed [DW-1:0] cf, f_add, frc_sum, acc_sat, vel_new, pos_new;

	cpfs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.stat  (div_stat)
	);

	cpfs_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(s_q),
		.root    (root),
		.stat    (sqrt_stat)
	);

	always_comb begin
		case (idx_q)
			2'd0: begin idx_j = 2'd1; idx_k = 2'd2; end
			2'd1: begin idx_j = 2'd2; idx_k = 2'd0; end
			default: begin idx_j = 2'd0; idx_k = 2'd1; end
		endcase
		idx_nxt = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
		pmag    = p_q[DEN_W-1] ? DEN_W'(-p_q) : DEN_W'(p_q);
		dmag    = d_q[idx_q][DW-1] ? DW'(-d_q[idx_q]) : DW'(d_q[idx_q]);
		cmag    = (CW-1)'(c_q[idx_q][CW-1] ? -c_q[idx_q] : c_q[idx_q]);
		q_force = (div_quo > CAP_FORCE) ? DW'(CAP_FORCE) : div_quo[DW-1:0];
		q_unit  = (div_quo > CAP_UNIT) ? (FB+1)'(CAP_UNIT) : div_quo[FB:0];
		prod_sh = $signed(prod_q[2*DW-1:FB]);
		cf      = $signed({1'b0, prod_q[DW+FB-2:FB]});
		if (state_q == ST_C_UF)
			f_add = (p_q[DEN_W-1] != d_q[idx_q][DW-1]) ? -cf : cf;
		else
			f_add = sat32(SATW'(prod_sh));
		frc_sum = sat32(SATW'(frc_q[idx_q]) + SATW'(f_add));
		acc_sat = sat32(SATW'(prod_sh));
		vel_new = sat32(SATW'(vel_q[idx_q]) + SATW'(acc_sat));
		pos_new = sat32(SATW'(pos_q[idx_q]) + SATW'(vel_new));
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		div_start     = 1'b0;
		div_num       = '0;
		div_den       = s_q;
		sqrt_start    = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (opcode_t'(s_axis_tuser))
						OP_PARTICLE, OP_WIRE: state_d = ST_DIFF;
						OP_TICK:              state_d = ST_T_MUL;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIFF: state_d = ST_SQ_MUL;
			ST_SQ_MUL: begin
				mul_a   = MW'(d_q[idx_q]);
				mul_b   = MW'(d_q[idx_q]);
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				if (idx_q != 2'd2)
					state_d = ST_SQ_MUL;
				else if (op_q == OP_PARTICLE)
					state_d = ST_C_CHK;
				else
					state_d = ST_L_CHK;
			end
			ST_C_CHK: begin
				if (s_q < NEAR_SQ) begin
					state_d = ST_IDLE;
				end else begin
					sqrt_start = 1'b1;
					mul_a      = MW'(oc_q);
					mul_b      = MW'(q2_q);
					state_d    = ST_C_P;
				end
			end
			ST_C_P: state_d = ST_C_G1;
			ST_C_G1: begin
				mul_a   = {1'b0, pmag[DEN_W-1:DW]};
				mul_b   = {1'b0, cg_q};
				state_d = ST_C_G2;
			end
			ST_C_G2: begin
				mul_a   = {1'b0, pmag[DW-1:0]};
				mul_b   = {1'b0, cg_q};
				state_d = ST_C_G3;
			end
			ST_C_G3: state_d = ST_C_DIVM;
			ST_C_DIVM: begin
				div_start = 1'b1;
				div_num   = NUM_W'(e_q) << FB;
				state_d   = ST_C_WAITM;
			end
			ST_C_WAITM: if (div_stat.done) state_d = ST_C_UDIV;
			ST_C_UDIV: begin
				div_start = 1'b1;
				div_num   = NUM_W'(dmag) << FB;
				div_den   = DEN_W'(root);
				state_d   = ST_C_UWAIT;
			end
			ST_C_UWAIT: begin
				mul_a = {1'b0, m_q};
				mul_b = MW'(q_unit);
				if (div_stat.done) state_d = ST_C_UF;
			end
			ST_C_UF: state_d = (idx_q == 2'd2) ? ST_IDLE : ST_C_UDIV;
			ST_L_CHK: state_d = (s_q == '0) ? ST_IDLE : ST_L_X1;
			ST_L_X1: begin
				mul_a   = MW'(d_q[idx_j]);
				mul_b   = MW'(w_q[idx_k]);
				state_d = ST_L_X2;
			end
			ST_L_X2: begin
				mul_a   = MW'(d_q[idx_k]);
				mul_b   = MW'(w_q[idx_j]);
				state_d = ST_L_X3;
			end
			ST_L_X3: state_d = (idx_q == 2'd2) ? ST_L_G1 : ST_L_X1;
			ST_L_G1: begin
				mul_a   = MW'(cmag[CW-2:DW]);
				mul_b   = {1'b0, mg_q};
				state_d = ST_L_G2;
			end
			ST_L_G2: begin
				mul_a   = {1'b0, cmag[DW-1:0]};
				mul_b   = {1'b0, mg_q};
				state_d = ST_L_G3;
			end
			ST_L_G3: state_d = ST_L_DIV;
			ST_L_DIV: begin
				div_start = 1'b1;
				div_num   = NUM_W'(e_q) << (2 * FB);
				state_d   = ST_L_DWAIT;
			end
			ST_L_DWAIT: begin
				if (div_stat.done)
					state_d = (idx_q == 2'd2) ? ST_L_V1 : ST_L_G1;
			end
			ST_L_V1: begin
				mul_a   = MW'(bf_q[idx_j]);
				mul_b   = MW'(vel_q[idx_k]);
				state_d = ST_L_V2;
			end
			ST_L_V2: begin
				mul_a   = MW'(bf_q[idx_k]);
				mul_b   = MW'(vel_q[idx_j]);
				state_d = ST_L_V3;
			end
			ST_L_V3: state_d = ST_L_V4;
			ST_L_V4: begin
				mul_a   = MW'(oc_q);
				mul_b   = MW'(x_q);
				state_d = ST_L_V5;
			end
			ST_L_V5: state_d = (idx_q == 2'd2) ? ST_IDLE : ST_L_V1;
			ST_T_MUL: begin
				mul_a   = MW'(frc_q[idx_q]);
				mul_b   = {2'b00, im_q};
				state_d = ST_T_UPD;
			end
			ST_T_UPD: state_d = (idx_q == 2'd2) ? ST_T_OUT : ST_T_MUL;
			ST_T_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
			cg_q        <= DW'(429497);
			mg_q        <= DW'(21474836);
			oc_q        <= DW'(65536);
			im_q        <= IM_W'(65536);
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				frc_q[i] <= '0;
				st_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_addr))
					REG_COULOMB_GAIN:  cg_q     <= cfg_wr_data;
					REG_MAGNETIC_GAIN: mg_q     <= cfg_wr_data;
					REG_OWN_CHARGE:    oc_q     <= $signed(cfg_wr_data);
					REG_INVERSE_MASS:  im_q     <= cfg_wr_data[IM_W-1:0];
					REG_START_X:       st_q[0]  <= $signed(cfg_wr_data);
					REG_START_Y:       st_q[1]  <= $signed(cfg_wr_data);
					REG_START_Z:       st_q[2]  <= $signed(cfg_wr_data);
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= 2'd0;
					if (s_axis_tvalid && opcode_t'(s_axis_tuser) == OP_RESTART) begin
						for (int i = 0; i < 3; i++) begin
							pos_q[i] <= st_q[i];
							vel_q[i] <= '0;
						end
					end
				end
				ST_SQ_ACC, ST_L_X3, ST_L_V5: idx_q <= idx_nxt;
				ST_C_WAITM: if (div_stat.done) idx_q <= 2'd0;
				ST_L_DWAIT: if (div_stat.done) idx_q <= idx_nxt;
				ST_C_UF: begin
					frc_q[idx_q] <= frc_sum;
					idx_q        <= idx_nxt;
				end
				ST_T_UPD: begin
					vel_q[idx_q] <= vel_new;
					pos_q[idx_q] <= pos_new;
					frc_q[idx_q] <= '0;
					idx_q        <= idx_nxt;
				end
				default: ;
			endcase
			if (state_q == ST_L_V5)
				frc_q[idx_q] <= frc_sum;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				op_q <= opcode_t'(s_axis_tuser);
				for (int i = 0; i < 3; i++) begin
					a_q[i] <= $signed(s_axis_tdata[i*DW +: DW]);
					b_q[i] <= $signed(s_axis_tdata[(i+3)*DW +: DW]);
				end
				q2_q <= $signed(s_axis_tdata[6*DW +: DW]);
			end
			ST_DIFF: begin
				s_q <= '0;
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= sat32(SATW'(pos_q[i]) - SATW'(a_q[i]));
					w_q[i] <= sat32(SATW'(b_q[i]) - SATW'(a_q[i]));
				end
			end
			ST_SQ_ACC:  s_q <= s_q + prod_q[DEN_W-1:0];
			ST_C_P:     p_q <= $signed(prod_q[DEN_W-1:0]);
			ST_C_G2, ST_L_G2: e_q <= prod_q[DEN_W-1:0];
			ST_C_G3, ST_L_G3: e_q <= e_q + DEN_W'(prod_q[2*DW-1:DW]);
			ST_C_WAITM: if (div_stat.done) m_q <= q_force;
			ST_L_X2, ST_L_V2: tmp_q <= prod_sh;
			ST_L_X3: c_q[idx_q] <= CW'(tmp_q) - CW'(prod_sh);
			ST_L_DWAIT: begin
				if (div_stat.done)
					bf_q[idx_q] <= c_q[idx_q][CW-1] ? -$signed(q_force) : $signed(q_force);
			end
			ST_L_V3: x_q <= sat32(SATW'(tmp_q) - SATW'(prod_sh));
			ST_T_OUT: begin
				if (out_load) begin
					for (int i = 0; i < 3; i++) begin
						out_q[i*DW +: DW]     <= pos_q[i];
						out_q[(i+3)*DW +: DW] <= vel_q[i];
					end
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`CPFS_ASSERT_NOW(a_div_start_idle, !div_start || !div_stat.busy, "divider restarted while busy")
	`CPFS_ASSERT_NOW(a_root_ready, state_q != ST_C_UDIV || sqrt_stat.done, "root not ready for unit vector")
	`CPFS_ASSERT_NEXT(a_result_from_tick, !m_axis_tvalid && state_q != ST_T_OUT, !m_axis_tvalid, "result without tick")
	`CPFS_ASSERT_NOW(a_force_cleared, state_q != ST_T_OUT || (frc_q[0] == '0 && frc_q[1] == '0 && frc_q[2] == '0), "force sum not cleared by tick")
endmodule

@@ src/cpfs_div.sv @@
// ----------------------------------------------------------------------------
// cpfs_div: restoring divider
// One quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module cpfs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cpfs_pkg::NUM_W-1:0]  num,
	input  logic [cpfs_pkg::DEN_W-1:0]  den,
	output logic [cpfs_pkg::NUM_W-1:0]  quo,
	output cpfs_pkg::unit_stat_t        stat
);
	import cpfs_pkg::*;

	logic [NUM_W-1:0]     quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       rem_sh;
	logic [DEN_W:0]       rem_sub;
	logic                 ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

@@ src/cpfs_sqrt.sv @@
// ----------------------------------------------------------------------------
// cpfs_sqrt: integer square root
// Digit-by-digit root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cpfs_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cpfs_pkg::DEN_W-1:0]  radicand,
	output logic [cpfs_pkg::ROOT_W-1:0] root,
	output cpfs_pkg::unit_stat_t        stat
);
	import cpfs_pkg::*;

	logic [DEN_W-1:0] n_q;
	logic [DEN_W-1:0] res_q;
	logic [DEN_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W-1:0] trial;
	logic             take;

	always_comb begin
		trial = res_q + bit_q;
		take  = n_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= DEN_W'(1) << (DEN_W - 2);
		end else if (busy_q) begin
			if (take) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root      = res_q[ROOT_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
